>>> sv/swrl_pkg.sv
// Package of types, states and constants for the sliding-window rate limiter.
`default_nettype none

package swrl_pkg;

  localparam logic [31:0] USEC_PER_SEC = 32'd1000000;
  localparam logic [31:0] FRAC_SCALE   = 32'd4294;
  localparam logic [31:0] WAIT_SCALE   = 32'd1000000;
  localparam logic [31:0] WAIT_MAX     = 32'hFFFF_FFFF;

  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] now_sec;
    logic [19:0] now_usec;
    logic [31:0] amount;
  } swrl_req_t;

  typedef struct packed {
    logic [31:0] wait_us;
    logic [31:0] remain;
    logic        over_limit;
  } swrl_rsp_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [31:0] quot;
  } swrl_div_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REC,
    S_FRAC,
    S_WGT,
    S_EST,
    S_CMP,
    S_MULX,
    S_DSTART,
    S_DWAIT,
    S_FIN
  } swrl_state_t;

endpackage

`default_nettype wire

>>> sv/swrl_div.sv
// Iterative 64-by-32 restoring divider with saturation of the 32-bit quotient.
`default_nettype none

module swrl_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [63:0]            dividend,
  input  logic [31:0]            divisor,
  output swrl_pkg::swrl_div_res_t res
);
  import swrl_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dsr;
  logic        done;
  logic        sat;
  logic [32:0] rem_sh;
  logic [32:0] rem_diff;
  logic        q_bit;

  always_comb begin
    rem_sh   = {rem, quo[31]};
    rem_diff = rem_sh - {1'b0, dsr};
    q_bit    = (rem_sh >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      sat  <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dsr <= divisor;
        cnt <= '0;
        if (dividend[63:32] >= divisor) begin
          sat  <= 1'b1;
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          sat  <= 1'b0;
          busy <= 1'b1;
          rem  <= dividend[63:32];
          quo  <= dividend[31:0];
        end
      end else if (busy) begin
        rem <= q_bit ? rem_diff[31:0] : rem_sh[31:0];
        quo <= {quo[30:0], q_bit};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = '{done: done, sat: sat, quot: quo};

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_busy_holds: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt != 5'd31 && !start) |=> busy)
    else $error("divider stopped early");
  a_sat_fast: assert property (@(posedge clk) disable iff (rst)
    (done && sat) |-> $past(start))
    else $error("saturated result not directly after start");

endmodule

`default_nettype wire

>>> sv/sliding_window_rate_limiter.sv
// Top level of the sliding-window rate limiter with its sequencer and shared multiplier.
//
//  channel | direction | handshake              | beat
//  req     | in        | req_valid / req_ready  | swrl_req_t: func, now_sec, now_usec, amount
//  rsp     | out       | rsp_valid / rsp_ready  | swrl_rsp_t: wait_us, remain, over_limit
//  cfg     | in        | cfg_write              | cfg_data: rate_limit
//
// A record beat passes from S_IDLE, where it is accepted, through S_REC to S_FIN.
// A query under the limit runs S_FRAC, S_WGT, S_EST and S_CMP to S_FIN; one over the limit
// adds S_MULX, S_DSTART and S_DWAIT, where a saturating wait skips the 32-step divide.
// All multiplications go through one 32-by-32 multiplier under the sequencer.
// Reset clears the window state, the limit and rsp_valid.
// A new request beat is taken while an earlier result still waits on rsp.
`default_nettype none

module sliding_window_rate_limiter (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  swrl_pkg::swrl_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output swrl_pkg::swrl_rsp_t rsp,
  input  logic                cfg_write,
  input  logic [31:0]         cfg_data
);
  import swrl_pkg::*;

  swrl_state_t   state;
  swrl_state_t   state_next;
  swrl_req_t     item;
  swrl_rsp_t     result;
  swrl_div_res_t div_res;

  logic [31:0] rate_limit;
  logic [31:0] window_second;
  logic [31:0] current_count;
  logic [31:0] previous_count;

  logic [31:0] frac;
  logic [31:0] weight;
  logic [31:0] est;
  logic [63:0] dividend;
  logic        age_zero;
  logic        age_one;

  logic [31:0] age;
  logic [31:0] older;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] wsum;
  logic [31:0] divisor;
  logic        div_start;
  logic        rsp_load;

  assign age     = item.now_sec - window_second;
  assign older   = age_zero ? previous_count : current_count;
  assign prod    = 64'(mul_a) * 64'(mul_b);
  assign wsum    = prod + {32'd0, older};
  assign divisor = (rate_limit != 32'd0) ? rate_limit : 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    div_start  = 1'b0;
    rsp_load   = 1'b0;
    mul_a      = 32'd0;
    mul_b      = 32'd0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = (req.func == FUNC_QUERY) ? S_FRAC : S_REC;
        end
      end
      S_REC: state_next = S_FIN;
      S_FRAC: begin
        mul_a      = USEC_PER_SEC - {12'd0, item.now_usec};
        mul_b      = FRAC_SCALE;
        state_next = S_WGT;
      end
      S_WGT: begin
        mul_a      = older;
        mul_b      = frac;
        state_next = S_EST;
      end
      S_EST: state_next = S_CMP;
      S_CMP: state_next = (est < rate_limit) ? S_FIN : S_MULX;
      S_MULX: begin
        mul_a      = est - rate_limit;
        mul_b      = WAIT_SCALE;
        state_next = S_DSTART;
      end
      S_DSTART: begin
        div_start  = 1'b1;
        state_next = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_res.done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_limit     <= 32'd0;
      window_second  <= 32'd0;
      current_count  <= 32'd0;
      previous_count <= 32'd0;
    end else begin
      if (cfg_write) begin
        rate_limit <= cfg_data;
      end
      if (state == S_REC) begin
        if (age == 32'd0) begin
          current_count <= current_count + item.amount;
        end else begin
          previous_count <= (age == 32'd1) ? current_count : 32'd0;
          window_second  <= item.now_sec;
          current_count  <= item.amount;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          item <= req;
        end
      end
      S_REC: result <= '0;
      S_FRAC: begin
        frac     <= prod[31:0];
        age_zero <= (age == 32'd0);
        age_one  <= (age == 32'd1);
      end
      S_WGT: weight <= wsum[63:32];
      S_EST: begin
        est <= (age_zero ? current_count : 32'd0)
             + ((age_zero || age_one) ? weight : 32'd0)
             + item.amount;
      end
      S_CMP: result <= '{wait_us: 32'd0, remain: rate_limit - est, over_limit: 1'b0};
      S_MULX: dividend <= prod;
      S_DWAIT: begin
        if (div_res.done) begin
          result.remain     <= 32'd0;
          result.over_limit <= 1'b1;
          if (div_res.sat) begin
            result.wait_us <= WAIT_MAX;
          end else if (div_res.quot == 32'd0) begin
            result.wait_us <= 32'd1;
          end else begin
            result.wait_us <= div_res.quot;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= result;
    end
  end

  swrl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .res      (div_res)
  );

endmodule

`default_nettype wire

>>> tb/sliding_window_rate_limiter_test.sv
// Testbench for the sliding-window rate limiter: directed and random beats checked by a predictor.
`timescale 1ns / 100ps

module sliding_window_rate_limiter_test;
  import swrl_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RX_ALWAYS = 0;
  localparam int RX_PATTERN = 1;
  localparam int RX_HEAVY = 2;
  localparam int RX_RANDOM = 3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  swrl_req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  swrl_rsp_t rsp;
  logic cfg_write = 1'b0;
  logic [31:0] cfg_data = '0;

  swrl_req_t pending_beats[$];
  swrl_rsp_t allowance_q[$];

  logic [31:0] lim = '0;
  logic [31:0] win_sec = '0;
  logic [31:0] cur_cnt = '0;
  logic [31:0] prev_cnt = '0;
  logic [31:0] gen_sec = '0;

  int cycles = 0;
  int mismatches = 0;
  int burst_left = 0;
  int gap_left = 0;
  int burst_max = 1;
  int gap_max = 0;
  int stall_mode = RX_ALWAYS;
  int n_record = 0;
  int n_query = 0;
  int n_over = 0;
  int n_sat = 0;
  int n_settings = 0;

  sliding_window_rate_limiter dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic swrl_rsp_t allowance_after(input swrl_req_t b);
    swrl_rsp_t r;
    logic [31:0] age;
    logic [31:0] frac;
    logic [31:0] older;
    logic [31:0] est;
    logic [31:0] excess;
    logic [31:0] divisor;
    logic [63:0] prod;
    logic [63:0] wait64;
    r = '0;
    age = b.now_sec - win_sec;
    if (b.func == FUNC_RECORD) begin
      n_record++;
      if (age == 32'd0) begin
        cur_cnt = cur_cnt + b.amount;
      end else begin
        prev_cnt = (age == 32'd1) ? cur_cnt : 32'd0;
        win_sec = b.now_sec;
        cur_cnt = b.amount;
      end
      return r;
    end
    n_query++;
    est = '0;
    if (age <= 32'd1) begin
      frac = (USEC_PER_SEC - {12'd0, b.now_usec}) * FRAC_SCALE;
      older = (age == 32'd0) ? prev_cnt : cur_cnt;
      est = (age == 32'd0) ? cur_cnt : 32'd0;
      prod = {32'd0, older} * {32'd0, frac} + {32'd0, older};
      est = est + prod[63:32];
    end
    est = est + b.amount;
    if (est < lim) begin
      r.remain = lim - est;
    end else begin
      excess = est - lim;
      divisor = (lim != 32'd0) ? lim : 32'd1;
      wait64 = ({32'd0, excess} * {32'd0, WAIT_SCALE}) / {32'd0, divisor};
      if (wait64 > {32'd0, WAIT_MAX}) begin
        wait64 = {32'd0, WAIT_MAX};
        n_sat++;
      end
      if (wait64 == 64'd0) begin
        wait64 = 64'd1;
      end
      r.wait_us = wait64[31:0];
      r.over_limit = 1'b1;
      n_over++;
    end
    return r;
  endfunction

  task automatic add_beat(input logic f, input logic [31:0] sec, input logic [19:0] usec,
                          input logic [31:0] amt);
    swrl_req_t b;
    b.func = f;
    b.now_sec = sec;
    b.now_usec = usec;
    b.amount = amt;
    pending_beats.push_back(b);
  endtask

  task automatic set_rate_limit(input logic [31:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    lim = v;
    @(posedge clk);
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || req_valid || allowance_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic pick_pacing(input bit busy);
    if (busy) begin
      burst_max = 1;
      gap_max = 0;
      stall_mode = RX_ALWAYS;
    end else begin
      burst_max = $urandom_range(1, 24);
      gap_max = $urandom_range(1, 10);
      stall_mode = $urandom_range(RX_ALWAYS, RX_RANDOM);
    end
  endtask

  task automatic fill_random(input int n);
    int pick;
    logic [31:0] scale;
    logic [31:0] amt;
    logic [19:0] usec;
    logic f;
    scale = (lim == 32'd0) ? 32'd1000 : ((lim > 32'd4000) ? lim / 4 : lim);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        gen_sec = $urandom;
      end else if (pick < 7) begin
        gen_sec = gen_sec - $urandom_range(1, 3);
      end else if (pick < 30) begin
        gen_sec = gen_sec + 32'd1;
      end else if (pick < 36) begin
        gen_sec = gen_sec + $urandom_range(2, 4);
      end
      usec = ($urandom_range(0, 99) < 5) ? 20'($urandom_range(1000000, 20'hFFFFF))
                                         : 20'($urandom_range(0, 999999));
      f = ($urandom_range(0, 99) < 55) ? FUNC_RECORD : FUNC_QUERY;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        amt = $urandom;
      end else if (pick < 8) begin
        amt = (pick[0]) ? 32'hFFFF_FFFF : 32'd0;
      end else begin
        amt = $urandom_range(0, scale);
      end
      add_beat(f, gen_sec, usec, amt);
    end
  endtask

  task automatic flag_mismatch(input string why, input swrl_rsp_t e, input swrl_rsp_t g);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected wait_us=%0d remain=%0d over_limit=%0b", $time, why,
               e.wait_us, e.remain, e.over_limit);
      $display("    got wait_us=%0d remain=%0d over_limit=%0b", g.wait_us, g.remain,
               g.over_limit);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (req_valid && req_ready) begin
        allowance_q.push_back(allowance_after(req));
      end
      if (!req_valid || req_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          req_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          req <= pending_beats.pop_front();
          req_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, burst_max);
            gap_left <= (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    swrl_rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (allowance_q.size() == 0) begin
          flag_mismatch("result beat with nothing expected", '0, rsp);
        end else begin
          want = allowance_q.pop_front();
          if (rsp.wait_us !== want.wait_us || rsp.remain !== want.remain ||
              rsp.over_limit !== want.over_limit) begin
            flag_mismatch("result beat differs", want, rsp);
          end
        end
      end
      case (stall_mode)
        RX_PATTERN: begin
          rsp_ready <= (cycles % 7) < 4;
        end
        RX_HEAVY: begin
          rsp_ready <= ($urandom_range(0, 3) == 0);
        end
        RX_RANDOM: begin
          rsp_ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          rsp_ready <= 1'b1;
        end
      endcase
    end
  end

  initial begin
    logic [31:0] phase_lims [9];
    phase_lims[0] = 32'd1;
    phase_lims[1] = 32'd10;
    phase_lims[2] = 32'd1000;
    phase_lims[3] = 32'd0;
    phase_lims[4] = 32'h8000_0000;
    phase_lims[5] = 32'hFFFF_FFFF;
    phase_lims[6] = 32'd50;
    phase_lims[7] = $urandom_range(1, 1000000);
    phase_lims[8] = $urandom;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Window bookkeeping with a limit of one hundred.
    set_rate_limit(32'd100);
    pick_pacing(1'b0);
    add_beat(FUNC_QUERY, 32'd0, 20'd0, 32'd0);
    add_beat(FUNC_RECORD, 32'd0, 20'd500000, 32'd60);
    add_beat(FUNC_RECORD, 32'd0, 20'h55555, 32'd30);
    add_beat(FUNC_QUERY, 32'd0, 20'd999999, 32'd9);
    add_beat(FUNC_QUERY, 32'd0, 20'hAAAAA, 32'd10);
    add_beat(FUNC_RECORD, 32'd1, 20'd0, 32'd20);
    add_beat(FUNC_QUERY, 32'd1, 20'd0, 32'd0);
    add_beat(FUNC_QUERY, 32'd1, 20'd999999, 32'd0);
    add_beat(FUNC_QUERY, 32'd1, 20'hFFFFF, 32'd0);
    add_beat(FUNC_QUERY, 32'd2, 20'd250000, 32'd5);
    add_beat(FUNC_QUERY, 32'd3, 20'd0, 32'hFFFF_FFFF);
    add_beat(FUNC_RECORD, 32'd5, 20'd0, 32'd0);
    add_beat(FUNC_RECORD, 32'd3, 20'd0, 32'd40);
    add_beat(FUNC_QUERY, 32'd2, 20'd0, 32'd0);
    add_beat(FUNC_RECORD, 32'd3, 20'd1, 32'hFFFF_FFFF);
    add_beat(FUNC_QUERY, 32'd3, 20'd2, 32'd61);
    add_beat(FUNC_RECORD, 32'hFFFF_FFFF, 20'd0, 32'd70);
    add_beat(FUNC_RECORD, 32'd0, 20'd0, 32'd1);
    add_beat(FUNC_QUERY, 32'd0, 20'd0, 32'hFFFF_FFFF);
    add_beat(FUNC_QUERY, 32'hFFFF_FFFF, 20'd0, 32'd100);
    drain();

    // A zero limit puts every query over, with the smallest and the saturated wait.
    set_rate_limit(32'd0);
    add_beat(FUNC_QUERY, 32'd9, 20'd0, 32'd0);
    add_beat(FUNC_QUERY, 32'd9, 20'd0, 32'd5000);
    drain();

    set_rate_limit(32'hFFFF_FFFF);
    add_beat(FUNC_QUERY, 32'd9, 20'd0, 32'hFFFF_FFFF);
    add_beat(FUNC_QUERY, 32'd9, 20'd0, 32'hFFFF_FFFE);
    drain();

    set_rate_limit(32'd1);
    add_beat(FUNC_QUERY, 32'd9, 20'd0, 32'd2);
    add_beat(FUNC_QUERY, 32'd9, 20'd0, 32'd0);
    drain();

    for (int p = 0; p < 9; p++) begin
      set_rate_limit(phase_lims[p]);
      pick_pacing(p == 2);
      fill_random(62);
      drain();
      fill_random(63);
      drain();
    end

    repeat (60) @(posedge clk);
    if (allowance_q.size() != 0) begin
      $display("%0d expected result beats never arrived.", allowance_q.size());
      mismatches += allowance_q.size();
    end
    $display("Ran %0d record and %0d query beats under %0d rate limit settings.",
             n_record, n_query, n_settings);
    $display("Of the queries, %0d were over the limit and %0d had a saturated wait.",
             n_over, n_sat);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
